// ===== rtl/cjm_pkg.sv =====
// shared types and constants for the complex 2x2 matrix unit
// no dependencies; imported by the divider and the top level
package cjm_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_ACC,
        ST_WRITE,
        ST_DIVS,
        ST_DIVW,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        PH_PROD,
        PH_TRI1,
        PH_TRI2,
        PH_DET,
        PH_NORM,
        PH_NUM
    } phase_t;

    localparam logic [3:0] CMD_AB      = 4'd0;
    localparam logic [3:0] CMD_ABT     = 4'd1;
    localparam logic [3:0] CMD_ABH     = 4'd2;
    localparam logic [3:0] CMD_ACC_AB  = 4'd3;
    localparam logic [3:0] CMD_ACC_ABT = 4'd4;
    localparam logic [3:0] CMD_ACC_ABH = 4'd5;
    localparam logic [3:0] CMD_ACC_AHB = 4'd6;
    localparam logic [3:0] CMD_ABCH    = 4'd7;
    localparam logic [3:0] CMD_INV     = 4'd8;

    typedef struct packed {
        logic done;
        logic ovf;
    } div_stat_t;

    // transpose of a 2x2 element index swaps row and column
    function automatic logic [1:0] swap_idx(input logic [1:0] i);
        return {i[0], i[1]};
    endfunction

endpackage

// ===== rtl/cjm_cmul.sv =====
// registered complex multiplier shared by all matrix steps
// no dependencies
module cjm_cmul #(
    parameter int W = 34
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [W-1:0]   x_re,
    input  logic signed [W-1:0]   x_im,
    input  logic signed [W-1:0]   y_re,
    input  logic signed [W-1:0]   y_im,
    output logic signed [2*W:0]   p_re,
    output logic signed [2*W:0]   p_im
);

    logic signed [2*W-1:0] rr, ii, ri, ir;
    logic signed [2*W:0]   p_re_reg, p_im_reg;

    always_comb
    begin
        rr = x_re * y_re;
        ii = x_im * y_im;
        ri = x_re * y_im;
        ir = x_im * y_re;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_re_reg <= (2*W+1)'(rr) - (2*W+1)'(ii);
            p_im_reg <= (2*W+1)'(ri) + (2*W+1)'(ir);
        end
    end

    assign p_re = p_re_reg;
    assign p_im = p_im_reg;

endmodule

// ===== rtl/cjm_div.sv =====
// restoring divider, one quotient bit per cycle, rounded to nearest
// depends on cjm_pkg for the status struct
module cjm_div #(
    parameter int NW = 93,
    parameter int DW = 69,
    parameter int QB = 33
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [NW-1:0]      num,
    input  logic [DW-1:0]      den,
    output cjm_pkg::div_stat_t stat,
    output logic [QB:0]        quot
);
    import cjm_pkg::*;

    localparam int CW = $clog2(QB + 1);

    logic          busy_reg, busy_next;
    logic          fin_reg, fin_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    div_stat_t     stat_reg, stat_next;
    logic [DW-1:0] rem_reg;
    logic [QB-1:0] low_reg;
    logic [QB-1:0] q_reg;
    logic [QB:0]   quot_reg;

    logic [DW:0]   sh;
    logic [DW:0]   den_x;
    logic          ge;
    logic [DW-1:0] hi_ext;
    logic          round_up;

    always_comb
    begin
        sh       = {rem_reg, low_reg[QB-1]};
        den_x    = {1'b0, den};
        ge       = (sh >= den_x);
        hi_ext   = DW'(num[NW-1:QB]);
        round_up = ({rem_reg, 1'b0} >= den_x);
    end

    always_comb
    begin
        busy_next      = busy_reg;
        fin_next       = 1'b0;
        cnt_next       = cnt_reg;
        stat_next      = stat_reg;
        stat_next.done = 1'b0;
        if (start)
        begin
            busy_next     = 1'b1;
            cnt_next      = CW'(QB);
            // quotient too large for the result width
            stat_next.ovf = ({1'b0, hi_ext} >= den_x);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            stat_next.done = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
            stat_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            cnt_reg  <= cnt_next;
            stat_reg <= stat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= hi_ext;
            low_reg <= num[QB-1:0];
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? DW'(sh - den_x) : sh[DW-1:0];
            low_reg <= {low_reg[QB-2:0], 1'b0};
            q_reg   <= {q_reg[QB-2:0], ge};
        end
        if (fin_reg)
        begin
            quot_reg <= (QB+1)'(q_reg) + (QB+1)'(round_up);
        end
    end

    assign stat = stat_reg;
    assign quot = quot_reg;

endmodule

// ===== rtl/complex_2x2_matrix_unit.sv =====
// complex 2x2 (jones) matrix unit: products, accumulation, triple product, inverse
// depends on cjm_pkg, cjm_cmul and cjm_div
//
// One beat in gives one beat out. The block holds a 2x2 complex result matrix
// (reset to zero) that every product command overwrites and every accumulate
// command adds to; the output beat always shows that matrix after the command,
// plus a singular flag (inverse of a matrix with zero determinant, which also
// zeroes the matrix) and a saturated flag (some component was clipped). All
// multiplications run through one registered complex multiplier under a small
// sequencer: a matrix element costs two multiplier passes plus one write step.
// The inverse uses the same multiplier for the determinant and its squared
// magnitude, then for each element a serial divider that makes one quotient
// bit a cycle for real and imaginary part in turn. in_stall stays high from
// accept until the result has been handed to the output register; a result
// waiting at the output does not stop the next beat from being accepted.
module complex_2x2_matrix_unit #(
    parameter int IN_COMPONENT_BITS  = 16,
    parameter int OUT_COMPONENT_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  cmd,
    input  logic [63:0] a_top,
    input  logic [63:0] a_bottom,
    input  logic [63:0] b_top,
    input  logic [63:0] b_bottom,
    input  logic [63:0] c_top,
    input  logic [63:0] c_bottom,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] out_e0,
    output logic [63:0] out_e1,
    output logic [63:0] out_e2,
    output logic [63:0] out_e3,
    output logic        singular,
    output logic        saturated
);
    import cjm_pkg::*;

    localparam int IB   = IN_COMPONENT_BITS;
    localparam int OB   = OUT_COMPONENT_BITS;
    localparam int IFR  = IB - 2;              // input fraction bits
    localparam int OFR  = OB - 4;              // output fraction bits
    localparam int LW   = 2 * IB + 2;          // multiplier operand width
    localparam int PW   = 2 * LW + 1;          // complex product width
    localparam int EW   = PW + 1;              // element sum width
    localparam int NMW  = 3 * IB + 3;          // inverse numerator magnitude width
    localparam int NW   = NMW + IFR + OFR;     // scaled dividend width
    localparam int QB   = OB + 1;              // quotient bits
    localparam int SH2  = 2 * IFR - OFR;       // rescale shift, two-matrix product
    localparam int SH3  = 3 * IFR - OFR;       // rescale shift, triple product
    localparam int LSH2 = (SH2 < 0) ? -SH2 : 0;
    localparam int LSH3 = (SH3 < 0) ? -SH3 : 0;
    localparam int LSH  = (LSH2 > LSH3) ? LSH2 : LSH3;
    localparam int RSW  = EW + LSH + 2;        // rescaled value plus accumulator headroom

    localparam logic signed [RSW-1:0] CLIP_HI = (RSW'(1) <<< (OB - 1)) - RSW'(1);
    localparam logic signed [RSW-1:0] CLIP_LO = -(RSW'(1) <<< (OB - 1));
    localparam logic signed [OB-1:0]  OUT_HI  = {1'b0, {(OB-1){1'b1}}};
    localparam logic signed [OB-1:0]  OUT_LO  = {1'b1, {(OB-1){1'b0}}};
    localparam logic [QB:0]           Q_HALF  = (QB+1)'(1) << (OB - 1);
    localparam logic [QB:0]           Q_MAX   = Q_HALF - (QB+1)'(1);

    // ---------------- helpers ----------------

    function automatic logic signed [IB-1:0] lane(input logic [63:0] top,
                                                  input logic [63:0] bottom,
                                                  input logic [1:0] e,
                                                  input logic im);
        logic [63:0] w;
        logic [5:0]  base;
        w    = e[1] ? bottom : top;
        base = {e[0], im, 4'd0};
        return w[base +: IB];
    endfunction

    function automatic logic signed [LW-1:0] ext(input logic signed [IB-1:0] v);
        return LW'(v);
    endfunction

    // round to nearest, ties toward plus infinity, or widen
    function automatic logic signed [RSW-1:0] rescale(input logic signed [EW-1:0] x,
                                                      input int sh);
        logic signed [RSW-1:0] xw;
        logic signed [RSW-1:0] half;
        xw   = RSW'(x);
        half = '0;
        if (sh > 0)
        begin
            half = RSW'(1) <<< (sh - 1);
            return (xw + half) >>> sh;
        end
        return xw <<< (-sh);
    endfunction

    function automatic logic signed [OB-1:0] clip_val(input logic signed [RSW-1:0] v);
        if (v > CLIP_HI)
            return OB'(CLIP_HI);
        if (v < CLIP_LO)
            return OB'(CLIP_LO);
        return OB'(v);
    endfunction

    function automatic logic is_clip(input logic signed [RSW-1:0] v);
        return (v > CLIP_HI) || (v < CLIP_LO);
    endfunction

    // ---------------- state ----------------

    state_t  state_reg, state_next;
    phase_t  phase_reg, phase_next;
    logic [1:0] e_reg, e_next;
    logic       t_reg, t_next;
    logic       part_reg, part_next;
    logic       sat_reg, sat_next;
    logic       sing_reg, sing_next;
    logic       out_valid_reg, out_valid_next;

    logic [3:0] cmd_reg;

    // operand matrices
    logic signed [IB-1:0] a_re_reg [4];
    logic signed [IB-1:0] a_im_reg [4];
    logic signed [IB-1:0] b_re_reg [4];
    logic signed [IB-1:0] b_im_reg [4];
    logic signed [IB-1:0] c_re_reg [4];
    logic signed [IB-1:0] c_im_reg [4];
    // intermediate a*b for the triple product
    logic signed [LW-1:0] t_re_reg [4];
    logic signed [LW-1:0] t_im_reg [4];
    // determinant and its squared magnitude
    logic signed [LW-1:0] d_re_reg, d_im_reg;
    logic [PW-1:0]        m_reg;
    // element sums
    logic signed [EW-1:0] psum_re_reg, psum_im_reg;
    logic signed [EW-1:0] esum_re_reg, esum_im_reg;
    logic signed [EW-1:0] esum_re_next, esum_im_next;
    // stored matrix
    logic signed [OB-1:0] acc_re_reg [4];
    logic signed [OB-1:0] acc_im_reg [4];
    // output beat
    logic [63:0]          out_e_reg [4];
    logic                 singular_reg, saturated_reg;

    // ---------------- control signals ----------------

    logic accept;
    logic mul_en;
    logic div_start;
    logic can_load;
    logic two_term;
    logic d_zero;
    logic wr_acc;
    logic accum;
    logic div_wr;

    assign accept   = in_valid && !in_stall;
    assign two_term = (phase_reg == PH_PROD) || (phase_reg == PH_TRI1) ||
                      (phase_reg == PH_TRI2) || (phase_reg == PH_DET);
    assign d_zero   = (d_re_reg == '0) && (d_im_reg == '0);

    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        mul_en    = (state_reg == ST_ISSUE);
        div_start = (state_reg == ST_DIVS);
        can_load  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    end

    // ---------------- multiplier operand selection ----------------

    logic [1:0] li, ri, a_idx, b_idx, c_idx;
    logic       b_swap, b_conj, a_conj;
    logic signed [LW-1:0] x_re, x_im, y_re, y_im;
    logic signed [LW-1:0] av_re, av_im, bv_re, bv_im;
    logic signed [PW-1:0] p_re_w, p_im_w;

    always_comb
    begin
        li     = {e_reg[1], t_reg};
        ri     = {t_reg, e_reg[0]};
        b_swap = (cmd_reg == CMD_ABT) || (cmd_reg == CMD_ABH) ||
                 (cmd_reg == CMD_ACC_ABT) || (cmd_reg == CMD_ACC_ABH);
        b_conj = (cmd_reg == CMD_ABH) || (cmd_reg == CMD_ACC_ABH);
        a_conj = (phase_reg == PH_PROD) && (cmd_reg == CMD_ACC_AHB);
        case (phase_reg)
            PH_PROD: a_idx = a_conj ? swap_idx(li) : li;
            PH_DET:  a_idx = {1'b0, t_reg};
            // adjugate: a3, a1, a2, a0
            PH_NUM:  a_idx = (e_reg[0] ^ e_reg[1]) ? e_reg : ~e_reg;
            default: a_idx = li;
        endcase
        b_idx = (b_swap && (phase_reg == PH_PROD)) ? swap_idx(ri) : ri;
        c_idx = swap_idx(ri);

        av_re = ext(a_re_reg[a_idx]);
        av_im = a_conj ? -ext(a_im_reg[a_idx]) : ext(a_im_reg[a_idx]);
        bv_re = ext(b_re_reg[b_idx]);
        bv_im = (b_conj && (phase_reg == PH_PROD)) ? -ext(b_im_reg[b_idx])
                                                   : ext(b_im_reg[b_idx]);

        case (phase_reg)
            PH_PROD, PH_TRI1:
            begin
                x_re = av_re;
                x_im = av_im;
                y_re = bv_re;
                y_im = bv_im;
            end
            PH_TRI2:
            begin
                x_re = t_re_reg[li];
                x_im = t_im_reg[li];
                y_re = ext(c_re_reg[c_idx]);
                y_im = -ext(c_im_reg[c_idx]);
            end
            PH_DET:
            begin
                // a0*a3, then a1*a2
                x_re = av_re;
                x_im = av_im;
                y_re = t_reg ? ext(a_re_reg[2]) : ext(a_re_reg[3]);
                y_im = t_reg ? ext(a_im_reg[2]) : ext(a_im_reg[3]);
            end
            PH_NORM:
            begin
                x_re = d_re_reg;
                x_im = d_im_reg;
                y_re = d_re_reg;
                y_im = -d_im_reg;
            end
            default:
            begin
                x_re = av_re;
                x_im = av_im;
                y_re = d_re_reg;
                y_im = -d_im_reg;
            end
        endcase
    end

    cjm_cmul #(
        .W (LW)
    ) u_cmul (
        .clk  (clk),
        .en   (mul_en),
        .x_re (x_re),
        .x_im (x_im),
        .y_re (y_re),
        .y_im (y_im),
        .p_re (p_re_w),
        .p_im (p_im_w)
    );

    // ---------------- element sum ----------------

    logic signed [EW-1:0] pe_re, pe_im;

    always_comb
    begin
        pe_re = EW'(p_re_w);
        pe_im = EW'(p_im_w);
        if (two_term)
        begin
            if ((phase_reg == PH_DET) && t_reg)
            begin
                esum_re_next = psum_re_reg - pe_re;
                esum_im_next = psum_im_reg - pe_im;
            end
            else
            begin
                esum_re_next = psum_re_reg + pe_re;
                esum_im_next = psum_im_reg + pe_im;
            end
        end
        else if ((phase_reg == PH_NUM) && (e_reg[0] ^ e_reg[1]))
        begin
            // off-diagonal adjugate terms are negated
            esum_re_next = -pe_re;
            esum_im_next = -pe_im;
        end
        else
        begin
            esum_re_next = pe_re;
            esum_im_next = pe_im;
        end
    end

    // ---------------- write-back value for products ----------------

    logic signed [RSW-1:0] rs_re, rs_im, sum_re, sum_im;
    logic signed [OB-1:0]  wr_re, wr_im;
    logic                  wr_sat;

    always_comb
    begin
        wr_acc = (state_reg == ST_WRITE) &&
                 ((phase_reg == PH_PROD) || (phase_reg == PH_TRI2));
        accum  = (phase_reg == PH_PROD) && (cmd_reg >= CMD_ACC_AB);
        if (phase_reg == PH_TRI2)
        begin
            rs_re = rescale(esum_re_reg, SH3);
            rs_im = rescale(esum_im_reg, SH3);
        end
        else
        begin
            rs_re = rescale(esum_re_reg, SH2);
            rs_im = rescale(esum_im_reg, SH2);
        end
        sum_re = rs_re + (accum ? RSW'(acc_re_reg[e_reg]) : RSW'(0));
        sum_im = rs_im + (accum ? RSW'(acc_im_reg[e_reg]) : RSW'(0));
        wr_re  = clip_val(sum_re);
        wr_im  = clip_val(sum_im);
        wr_sat = is_clip(sum_re) || is_clip(sum_im);
    end

    // ---------------- divider for the inverse ----------------

    logic signed [EW-1:0] dv;
    logic                 div_neg;
    logic [EW-1:0]        div_mag;
    logic [NW-1:0]        div_num;
    div_stat_t            div_stat;
    logic [QB:0]          div_q;
    logic                 div_over;
    logic signed [OB-1:0] div_val;

    always_comb
    begin
        dv       = part_reg ? esum_im_reg : esum_re_reg;
        div_neg  = dv[EW-1];
        div_mag  = div_neg ? EW'(-dv) : EW'(dv);
        div_num  = {div_mag[NMW-1:0], {(IFR+OFR){1'b0}}};
        div_wr   = (state_reg == ST_DIVW) && div_stat.done;
        div_over = div_stat.ovf || (div_neg ? (div_q > Q_HALF) : (div_q > Q_MAX));
        if (div_over)
            div_val = div_neg ? OUT_LO : OUT_HI;
        else if (div_neg)
            div_val = -OB'(div_q);
        else
            div_val = OB'(div_q);
    end

    cjm_div #(
        .NW (NW),
        .DW (PW),
        .QB (QB)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (m_reg),
        .stat  (div_stat),
        .quot  (div_q)
    );

    // ---------------- next state ----------------

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = (cmd <= CMD_INV) ? ST_ISSUE : ST_DONE;
            end
            ST_ISSUE:
                state_next = ST_ACC;
            ST_ACC:
                state_next = (two_term && !t_reg) ? ST_ISSUE : ST_WRITE;
            ST_WRITE:
            begin
                case (phase_reg)
                    PH_PROD, PH_TRI2: state_next = (e_reg == 2'd3) ? ST_DONE : ST_ISSUE;
                    PH_NORM:          state_next = d_zero ? ST_DONE : ST_ISSUE;
                    PH_NUM:           state_next = ST_DIVS;
                    default:          state_next = ST_ISSUE;
                endcase
            end
            ST_DIVS:
                state_next = ST_DIVW;
            ST_DIVW:
            begin
                if (div_stat.done)
                begin
                    if (!part_reg)
                        state_next = ST_DIVS;
                    else
                        state_next = (e_reg == 2'd3) ? ST_DONE : ST_ISSUE;
                end
            end
            ST_DONE:
            begin
                if (can_load)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ---------------- sequencer counters and flags ----------------

    always_comb
    begin
        phase_next     = phase_reg;
        e_next         = e_reg;
        t_next         = t_reg;
        part_next      = part_reg;
        sat_next       = sat_reg;
        sing_next      = sing_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (can_load)
            out_valid_next = 1'b1;

        if (accept)
        begin
            e_next    = 2'd0;
            t_next    = 1'b0;
            part_next = 1'b0;
            sat_next  = 1'b0;
            sing_next = 1'b0;
            if (cmd == CMD_ABCH)
                phase_next = PH_TRI1;
            else if (cmd == CMD_INV)
                phase_next = PH_DET;
            else
                phase_next = PH_PROD;
        end

        if (state_reg == ST_ACC)
            t_next = two_term && !t_reg;

        if (state_reg == ST_WRITE)
        begin
            case (phase_reg)
                PH_PROD, PH_TRI2:
                begin
                    e_next   = e_reg + 2'd1;
                    sat_next = sat_reg || wr_sat;
                end
                PH_TRI1:
                begin
                    e_next = e_reg + 2'd1;
                    if (e_reg == 2'd3)
                        phase_next = PH_TRI2;
                end
                PH_DET:
                    phase_next = PH_NORM;
                PH_NORM:
                begin
                    e_next     = 2'd0;
                    phase_next = PH_NUM;
                    if (d_zero)
                        sing_next = 1'b1;
                end
                PH_NUM:
                    part_next = 1'b0;
                default:
                    phase_next = phase_reg;
            endcase
        end

        if (div_wr)
        begin
            sat_next  = sat_reg || div_over;
            part_next = !part_reg;
            if (part_reg)
                e_next = e_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_PROD;
            e_reg         <= 2'd0;
            t_reg         <= 1'b0;
            part_reg      <= 1'b0;
            sat_reg       <= 1'b0;
            sing_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            e_reg         <= e_next;
            t_reg         <= t_next;
            part_reg      <= part_next;
            sat_reg       <= sat_next;
            sing_reg      <= sing_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------- stored matrix ----------------

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                acc_re_reg[i] <= '0;
                acc_im_reg[i] <= '0;
            end
        end
        else if (wr_acc)
        begin
            acc_re_reg[e_reg] <= wr_re;
            acc_im_reg[e_reg] <= wr_im;
        end
        else if ((state_reg == ST_WRITE) && (phase_reg == PH_NORM) && d_zero)
        begin
            // singular matrix clears the result
            for (int i = 0; i < 4; i++)
            begin
                acc_re_reg[i] <= '0;
                acc_im_reg[i] <= '0;
            end
        end
        else if (div_wr)
        begin
            if (part_reg)
                acc_im_reg[e_reg] <= div_val;
            else
                acc_re_reg[e_reg] <= div_val;
        end
    end

    // ---------------- datapath registers ----------------

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
            for (int i = 0; i < 4; i++)
            begin
                a_re_reg[i] <= lane(a_top, a_bottom, 2'(i), 1'b0);
                a_im_reg[i] <= lane(a_top, a_bottom, 2'(i), 1'b1);
                b_re_reg[i] <= lane(b_top, b_bottom, 2'(i), 1'b0);
                b_im_reg[i] <= lane(b_top, b_bottom, 2'(i), 1'b1);
                c_re_reg[i] <= lane(c_top, c_bottom, 2'(i), 1'b0);
                c_im_reg[i] <= lane(c_top, c_bottom, 2'(i), 1'b1);
            end
        end
        if (state_reg == ST_ACC)
        begin
            if (two_term && !t_reg)
            begin
                psum_re_reg <= pe_re;
                psum_im_reg <= pe_im;
            end
            else
            begin
                esum_re_reg <= esum_re_next;
                esum_im_reg <= esum_im_next;
            end
        end
        if (state_reg == ST_WRITE)
        begin
            case (phase_reg)
                PH_TRI1:
                begin
                    t_re_reg[e_reg] <= LW'(esum_re_reg);
                    t_im_reg[e_reg] <= LW'(esum_im_reg);
                end
                PH_DET:
                begin
                    d_re_reg <= LW'(esum_re_reg);
                    d_im_reg <= LW'(esum_im_reg);
                end
                PH_NORM:
                    m_reg <= PW'(esum_re_reg);
                default:
                    m_reg <= m_reg;
            endcase
        end
        if (can_load)
        begin
            for (int i = 0; i < 4; i++)
                out_e_reg[i] <= {32'(acc_im_reg[i]), 32'(acc_re_reg[i])};
            singular_reg  <= sing_reg;
            saturated_reg <= sat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_e0    = out_e_reg[0];
    assign out_e1    = out_e_reg[1];
    assign out_e2    = out_e_reg[2];
    assign out_e3    = out_e_reg[3];
    assign singular  = singular_reg;
    assign saturated = saturated_reg;

    // ---------------- assertions ----------------

    // singular beat carries an all-zero matrix and never a clip
    a_singular_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && singular_reg |-> !saturated_reg &&
            out_e_reg[0] == 64'd0 && out_e_reg[1] == 64'd0 &&
            out_e_reg[2] == 64'd0 && out_e_reg[3] == 64'd0)
        else $error("singular result not cleared");

    // divider results only arrive while the sequencer waits for them
    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIVW)
        else $error("divider finished outside wait state");

    // an accepted beat starts work
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE)
        else $error("accepted beat did not start");

    // a new result beat only comes out of the done state
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result beat raised outside done state");

endmodule
